// ===== rtl/nhpjw_pkg.sv =====
`default_nettype none

package nhpjw_pkg;

  localparam int unsigned HashW = 32;

  localparam logic [7:0]       LeadMask      = 8'hFE;
  localparam logic [7:0]       LeadCode      = 8'hC2;
  localparam logic [7:0]       ContMask      = 8'hC0;
  localparam logic [7:0]       ContCode      = 8'h80;
  localparam logic [7:0]       ContBits      = 8'h3F;
  localparam logic [HashW-1:0] TopNibbleMask = 32'hF000_0000;
  localparam int unsigned      FoldShift     = 24;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic             held;
    logic             low_bit;
  } hash_state_t;

  // one pjw round: shift in a byte, fold the top nibble back
  function automatic logic [HashW-1:0] pjw_update(input logic [HashW-1:0] h,
                                                  input logic [7:0]       v);
    logic [HashW-1:0] s;
    logic [HashW-1:0] g;
    s = {h[HashW-5:0], 4'b0000} + {{(HashW-8){1'b0}}, v};
    g = s & TopNibbleMask;
    pjw_update = s ^ (g >> FoldShift) ^ g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nhpjw_step.sv =====
`default_nettype none

module nhpjw_step
  import nhpjw_pkg::*;
(
  input  wire hash_state_t      state_i,
  input  wire logic [7:0]       name_byte_i,
  input  wire logic             last_byte_i,
  output hash_state_t           state_nxt_o,
  output logic [HashW-1:0]      hash_o
);

  logic             is_cont;
  logic             is_lead;
  logic             consumed;
  logic [7:0]       held_val;
  logic [HashW-1:0] h1;
  logic [HashW-1:0] h2;
  logic             hold_new;

  assign is_cont  = (name_byte_i & ContMask) == ContCode;
  assign is_lead  = (name_byte_i & LeadMask) == LeadCode;
  assign consumed = state_i.held & is_cont;

  // folded latin-1 code, or the lone lead byte when no continuation follows
  assign held_val = is_cont ? (ContCode | {1'b0, state_i.low_bit, 6'b0} |
                               (name_byte_i & ContBits))
                            : (LeadCode | {7'b0, state_i.low_bit});

  assign h1       = state_i.held ? pjw_update(state_i.hash, held_val) : state_i.hash;
  assign hold_new = !consumed && !last_byte_i && is_lead;
  assign h2       = (consumed || hold_new) ? h1 : pjw_update(h1, name_byte_i);

  assign hash_o = h2;

  always_comb begin
    if (last_byte_i) begin
      state_nxt_o = '0;
    end else begin
      state_nxt_o.hash    = h2;
      state_nxt_o.held    = hold_new;
      state_nxt_o.low_bit = hold_new & name_byte_i[0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/name_hash_pjw_latin1_fold.sv =====
`default_nettype none

// PJW (ELF-style) 32-bit name hash with a Latin-1 fold: bytes of a name arrive one
// beat per cycle, in_tlast marks the final byte, and the hash of the whole name
// leaves as one out beat for each name. A C2/C3 lead byte followed by a continuation
// byte is hashed as its single Latin-1 code. The block takes a beat every cycle;
// a beat is registered, then hashed combinationally into the running state and,
// on the final byte, into the output register, which raises out_tvalid once that
// register is free to take the result. Only a stalled result with another
// final byte behind it holds the input back.
module name_hash_pjw_latin1_fold
  import nhpjw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] name_byte
  input  wire logic             in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [HashW-1:0]      out_tdata   // [31:0] hash_value
);

  logic             in_v_r;
  logic [7:0]       byte_r;
  logic             last_r;
  hash_state_t      state_r;
  hash_state_t      state_nxt;
  logic [HashW-1:0] step_hash;
  logic             out_v_r;
  logic [HashW-1:0] out_data_r;
  logic             out_free;
  logic             fire;
  logic             in_acc;

  assign out_free  = !out_v_r || out_tready;
  assign fire      = in_v_r && (!last_r || out_free);
  assign in_tready = !in_v_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  nhpjw_step u_step (
    .state_i     (state_r),
    .name_byte_i (byte_r),
    .last_byte_i (last_r),
    .state_nxt_o (state_nxt),
    .hash_o      (step_hash)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      state_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      if (fire && last_r) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (fire && last_r) begin
      out_data_r <= step_hash;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // a final byte leaves the running state clear
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_r) |=> (state_r.hash == '0 && !state_r.held))
    else $error("state not cleared after final byte");

  // low bit of a lead is only kept while a lead is held
  a_low_bit_held: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.held |-> !state_r.low_bit)
    else $error("lead low bit set with no lead held");

  // a result only appears from a processed final byte
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(fire && last_r))
    else $error("result without a final byte");

  // a lead is never held across a processed final byte
  a_no_hold_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_r) |-> !state_nxt.held)
    else $error("lead held on final byte");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench
  import nhpjw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             fixed;
    logic [HashW-1:0] hash;
  } name_beat_t;

  localparam int NumDirected = 26;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;  // [7:0] name_byte
  logic             in_tlast   = 1'b0;   // last_byte
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [HashW-1:0] out_tdata;           // [31:0] hash_value

  // typed-in expectation travelling with the beat on the bus
  logic             stim_fixed      = 1'b0;
  logic [HashW-1:0] stim_fixed_hash = '0;

  name_beat_t       name_beats[$];
  logic [HashW-1:0] hash_expected_q[$];
  int               fail_count = 0;
  int               mid_index  = -1;

  // predicted block state
  logic [HashW-1:0] pjw_running = '0;
  logic             lead_waiting = 1'b0;
  logic             lead_bit0    = 1'b0;

  name_hash_pjw_latin1_fold dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [HashW-1:0] pjw_round(input logic [HashW-1:0] h,
                                                 input logic [7:0]       v);
    logic [HashW-1:0] acc;
    logic [HashW-1:0] top;
    acc = (h << 4) + HashW'(v);
    top = acc & TopNibbleMask;
    if (top != '0) begin
      acc = acc ^ (top >> FoldShift);
      acc = acc ^ top;
    end
    return acc;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] lead_byte();
    return {7'b1100001, 1'($urandom_range(1))};
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0, 1, 2: return lead_byte();
      3, 4, 5: return cont_byte();
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_stimulus();
    name_beat_t directed_rows[NumDirected] = '{
      '{8'h00, 1'b1, 1'b1, 32'h0000_0000},
      '{8'hFF, 1'b1, 1'b1, 32'h0000_00FF},
      // lead byte as the final byte is hashed alone
      '{8'hC2, 1'b1, 1'b1, 32'h0000_00C2},
      '{8'hC3, 1'b1, 1'b1, 32'h0000_00C3},
      '{8'hC3, 1'b0, 1'b0, 32'h0},
      '{8'hA9, 1'b1, 1'b1, 32'h0000_00E9},
      '{8'hC2, 1'b0, 1'b0, 32'h0},
      '{8'h80, 1'b1, 1'b1, 32'h0000_0080},
      // held lead followed by a plain byte
      '{8'hC2, 1'b0, 1'b0, 32'h0},
      '{8'h41, 1'b1, 1'b0, 32'h0},
      // held lead followed by another lead, which then folds
      '{8'hC2, 1'b0, 1'b0, 32'h0},
      '{8'hC3, 1'b0, 1'b0, 32'h0},
      '{8'hBF, 1'b1, 1'b0, 32'h0},
      '{8'hC3, 1'b0, 1'b0, 32'h0},
      '{8'hC2, 1'b1, 1'b0, 32'h0},
      '{8'h80, 1'b0, 1'b0, 32'h0},
      '{8'h3F, 1'b1, 1'b0, 32'h0},
      // long run so the top nibble folds back
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b1, 1'b0, 32'h0}
    };
    name_beat_t beat;
    int         len;
    int         k;
    bit         well_formed;
    foreach (directed_rows[i]) name_beats.push_back(directed_rows[i]);
    while (name_beats.size() < NumDirected + 400) begin
      if (mid_index < 0 && name_beats.size() >= NumDirected + 200)
        mid_index = name_beats.size();
      len         = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      well_formed = ($urandom_range(3) != 0);
      k           = 0;
      while (k < len) begin
        beat = '0;
        if (well_formed && k < len - 1 && $urandom_range(1)) begin
          beat.data = lead_byte();
          name_beats.push_back(beat);
          beat.data = cont_byte();
          k += 2;
        end else if (well_formed) begin
          beat.data = {1'b0, 7'($urandom)};
          k++;
        end else begin
          beat.data = noise_byte();
          k++;
        end
        beat.last = (k >= len);
        name_beats.push_back(beat);
      end
    end
  endtask

  // sender
  initial begin
    int gap;
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < name_beats.size(); i++) begin
      if (i == NumDirected || i == mid_index) begin
        // hold off until the block has drained every pending hash
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (hash_expected_q.size() != 0) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_tvalid       <= 1'b1;
      in_tdata        <= name_beats[i].data;
      in_tlast        <= name_beats[i].last;
      stim_fixed      <= name_beats[i].fixed;
      stim_fixed_hash <= name_beats[i].hash;
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (hash_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && hash_expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver with random stalls
  initial begin
    int stall;
    repeat (6) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin
    logic             folded;
    logic [HashW-1:0] want;
    if (rst_n && in_tvalid && in_tready) begin
      folded = 1'b0;
      if (lead_waiting) begin
        if ((in_tdata & ContMask) == ContCode) begin
          pjw_running = pjw_round(pjw_running,
                                  ContCode | {1'b0, lead_bit0, 6'b0} | (in_tdata & ContBits));
          folded = 1'b1;
        end else begin
          pjw_running = pjw_round(pjw_running, LeadCode | {7'b0, lead_bit0});
        end
        lead_waiting = 1'b0;
        lead_bit0    = 1'b0;
      end
      if (!folded) begin
        if (!in_tlast && (in_tdata & LeadMask) == LeadCode) begin
          lead_waiting = 1'b1;
          lead_bit0    = in_tdata[0];
        end else begin
          pjw_running = pjw_round(pjw_running, in_tdata);
        end
      end
      if (in_tlast) begin
        hash_expected_q.push_back(stim_fixed ? stim_fixed_hash : pjw_running);
        pjw_running  = '0;
        lead_waiting = 1'b0;
        lead_bit0    = 1'b0;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expected_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected hash beat %h", out_tdata);
        fail_count++;
      end else begin
        want = hash_expected_q.pop_front();
        if (out_tdata !== want) begin
          if (fail_count < 10)
            $display("hash_value mismatch: expected %h actual %h", want, out_tdata);
          fail_count++;
        end
      end
    end
  end

endmodule

`default_nettype wire
